// ===== design/ps2dch_pkg.sv =====
// ----------------------------------------------------------------------------
// ps2dch_pkg
// Shared types and constants for the PS/2 device command handshake unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ps2dch_pkg;

  localparam int MAX_ID_BYTES = 32;
  localparam int CNT_W        = $clog2(MAX_ID_BYTES + 1);
  localparam int TICK_W       = 4;
  localparam int CFG_W        = 6;

  // event codes carried on in_tuser
  typedef enum logic [2:0] {
    OP_RESET   = 3'd0,
    OP_IDENT   = 3'd1,
    OP_ENABLE  = 3'd2,
    OP_DISABLE = 3'd3,
    OP_RXBYTE  = 3'd4,
    OP_TICK    = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    CMD_RESET   = 2'd0,
    CMD_IDENT   = 2'd1,
    CMD_ENABLE  = 2'd2,
    CMD_DISABLE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_TX     = 2'd0,
    KIND_ID     = 2'd1,
    KIND_FINISH = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NODEV   = 3'd1,
    ST_INVALID = 3'd2,
    ST_TIMEOUT = 3'd3,
    ST_TOOLONG = 3'd4
  } status_t;

  typedef enum logic [0:0] {
    REG_WAIT_TICKS  = 1'b0,
    REG_ID_CAPACITY = 1'b1
  } reg_idx_t;

  localparam logic [TICK_W-1:0] WAIT_TICKS_RST  = TICK_W'(10);
  localparam logic [CFG_W-1:0]  ID_CAPACITY_RST = CFG_W'(32);

  // device protocol bytes
  localparam logic [7:0] B_RESET    = 8'hFF;
  localparam logic [7:0] B_IDENT    = 8'hF2;
  localparam logic [7:0] B_ENABLE   = 8'hF4;
  localparam logic [7:0] B_DISABLE  = 8'hF5;
  localparam logic [7:0] B_ACK      = 8'hFA;
  localparam logic [7:0] B_RESEND   = 8'hFE;
  localparam logic [7:0] B_BAT_OK   = 8'hAA;

  typedef struct packed {
    logic [CNT_W-1:0] id_count;
    status_t          status;
    logic [7:0]       payload;
    kind_t            kind;
  } res_t;

endpackage

`default_nettype wire

// ===== design/ps2dch_seq.sv =====
// ----------------------------------------------------------------------------
// ps2dch_seq
// Command sequencer state and per-event update; one event per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2dch_seq (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          ev_valid,
  input  wire logic [2:0]                    ev_op,
  input  wire logic [7:0]                    ev_byte,
  input  wire logic [ps2dch_pkg::TICK_W-1:0] wait_ticks,
  input  wire logic [ps2dch_pkg::CFG_W-1:0]  id_capacity,
  output logic                               res_valid,
  output ps2dch_pkg::res_t                   res
);

  typedef enum logic [8:0] {
    PH_IDLE       = 9'b000000001,
    PH_DIS_ACK    = 9'b000000010,
    PH_EN_ACK     = 9'b000000100,
    PH_RST_R1     = 9'b000001000,
    PH_RST_R2     = 9'b000010000,
    PH_RST_DRAIN  = 9'b000100000,
    PH_ID_ACK     = 9'b001000000,
    PH_ID_COLLECT = 9'b010000000,
    PH_ID_EXTRA   = 9'b100000000
  } phase_t;

  localparam int CNT_W = ps2dch_pkg::CNT_W;
  localparam int TW    = ps2dch_pkg::TICK_W;

  phase_t               phase_r, phase_nxt;
  ps2dch_pkg::cmd_t     cmd_r, cmd_nxt;
  logic [TW-1:0]        tick_r, tick_nxt;
  logic [CNT_W-1:0]     coll_r, coll_nxt;

  logic [TW:0]          tick_inc;
  logic                 timeout;
  logic [CNT_W-1:0]     cap;
  logic [CNT_W-1:0]     coll_inc;
  ps2dch_pkg::op_t      op;

  assign op       = ps2dch_pkg::op_t'(ev_op);
  assign tick_inc = {1'b0, tick_r} + (TW+1)'(1);
  assign timeout  = tick_inc >= {1'b0, wait_ticks};
  assign coll_inc = coll_r + CNT_W'(1);

  // capacity clamped to 1..MAX_ID_BYTES
  always_comb begin
    if (id_capacity == '0) begin
      cap = CNT_W'(1);
    end else if (CNT_W'(id_capacity) > CNT_W'(ps2dch_pkg::MAX_ID_BYTES)) begin
      cap = CNT_W'(ps2dch_pkg::MAX_ID_BYTES);
    end else begin
      cap = CNT_W'(id_capacity);
    end
  end

  always_comb begin
    logic             do_tx;
    logic             do_fin;
    logic [7:0]       tx_byte;
    phase_t           tx_phase;
    ps2dch_pkg::status_t fin_st;

    do_tx     = 1'b0;
    do_fin    = 1'b0;
    tx_byte   = '0;
    tx_phase  = phase_r;
    fin_st    = ps2dch_pkg::ST_OK;
    phase_nxt = phase_r;
    cmd_nxt   = cmd_r;
    tick_nxt  = tick_r;
    coll_nxt  = coll_r;
    res_valid = 1'b0;
    res       = '0;

    if (ev_valid) begin
      unique case (op)
        ps2dch_pkg::OP_RESET, ps2dch_pkg::OP_IDENT,
        ps2dch_pkg::OP_ENABLE, ps2dch_pkg::OP_DISABLE: begin
          if (phase_r == PH_IDLE) begin
            cmd_nxt  = ps2dch_pkg::cmd_t'(ev_op[1:0]);
            coll_nxt = '0;
            do_tx    = 1'b1;
            if (op == ps2dch_pkg::OP_ENABLE) begin
              tx_byte  = ps2dch_pkg::B_ENABLE;
              tx_phase = PH_EN_ACK;
            end else begin
              tx_byte  = ps2dch_pkg::B_DISABLE;
              tx_phase = PH_DIS_ACK;
            end
          end
        end
        ps2dch_pkg::OP_RXBYTE: begin
          if (phase_r != PH_IDLE) begin
            tick_nxt = '0;
            unique case (phase_r)
              PH_DIS_ACK: begin
                if (ev_byte == ps2dch_pkg::B_RESEND) begin
                  do_tx    = 1'b1;
                  tx_byte  = ps2dch_pkg::B_DISABLE;
                  tx_phase = PH_DIS_ACK;
                end else if (ev_byte != ps2dch_pkg::B_ACK) begin
                  do_fin = 1'b1;
                  fin_st = ps2dch_pkg::ST_INVALID;
                end else if (cmd_r == ps2dch_pkg::CMD_RESET) begin
                  do_tx    = 1'b1;
                  tx_byte  = ps2dch_pkg::B_RESET;
                  tx_phase = PH_RST_R1;
                end else if (cmd_r == ps2dch_pkg::CMD_IDENT) begin
                  do_tx    = 1'b1;
                  tx_byte  = ps2dch_pkg::B_IDENT;
                  tx_phase = PH_ID_ACK;
                end else begin
                  do_fin = 1'b1;
                end
              end
              PH_EN_ACK: begin
                if (ev_byte == ps2dch_pkg::B_RESEND) begin
                  do_tx    = 1'b1;
                  tx_byte  = ps2dch_pkg::B_ENABLE;
                  tx_phase = PH_EN_ACK;
                end else begin
                  do_fin = 1'b1;
                  fin_st = (ev_byte == ps2dch_pkg::B_ACK) ? ps2dch_pkg::ST_OK
                                                          : ps2dch_pkg::ST_INVALID;
                end
              end
              PH_RST_R1, PH_RST_R2: begin
                if (ev_byte != ps2dch_pkg::B_ACK && ev_byte != ps2dch_pkg::B_BAT_OK) begin
                  do_fin = 1'b1;
                  fin_st = ps2dch_pkg::ST_INVALID;
                end else begin
                  phase_nxt = (phase_r == PH_RST_R1) ? PH_RST_R2 : PH_RST_DRAIN;
                end
              end
              PH_RST_DRAIN: begin
              end
              PH_ID_ACK: begin
                if (ev_byte == ps2dch_pkg::B_RESEND) begin
                  do_tx    = 1'b1;
                  tx_byte  = ps2dch_pkg::B_IDENT;
                  tx_phase = PH_ID_ACK;
                end else if (ev_byte != ps2dch_pkg::B_ACK) begin
                  do_fin = 1'b1;
                  fin_st = ps2dch_pkg::ST_INVALID;
                end else begin
                  phase_nxt = PH_ID_COLLECT;
                  coll_nxt  = '0;
                end
              end
              PH_ID_COLLECT: begin
                coll_nxt  = coll_inc;
                if (coll_inc >= cap) begin
                  phase_nxt = PH_ID_EXTRA;
                end
                res_valid   = 1'b1;
                res.kind    = ps2dch_pkg::KIND_ID;
                res.payload = ev_byte;
              end
              PH_ID_EXTRA: begin
                do_fin = 1'b1;
                fin_st = ps2dch_pkg::ST_TOOLONG;
              end
              default: begin
              end
            endcase
          end
        end
        ps2dch_pkg::OP_TICK: begin
          if (phase_r != PH_IDLE) begin
            tick_nxt = tick_inc[TW-1:0];
            if (timeout) begin
              do_fin = 1'b1;
              priority case (phase_r)
                PH_RST_R1:                                fin_st = ps2dch_pkg::ST_NODEV;
                PH_RST_DRAIN, PH_ID_COLLECT, PH_ID_EXTRA: fin_st = ps2dch_pkg::ST_OK;
                default:                                  fin_st = ps2dch_pkg::ST_TIMEOUT;
              endcase
            end
          end
        end
        default: begin
        end
      endcase

      if (do_tx) begin
        phase_nxt   = tx_phase;
        tick_nxt    = '0;
        res_valid   = 1'b1;
        res.kind    = ps2dch_pkg::KIND_TX;
        res.payload = tx_byte;
      end
      if (do_fin) begin
        phase_nxt    = PH_IDLE;
        tick_nxt     = '0;
        res_valid    = 1'b1;
        res.kind     = ps2dch_pkg::KIND_FINISH;
        res.status   = fin_st;
        res.id_count = (cmd_r == ps2dch_pkg::CMD_IDENT) ? coll_r : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cmd_r   <= ps2dch_pkg::CMD_RESET;
      tick_r  <= '0;
      coll_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      cmd_r   <= cmd_nxt;
      tick_r  <= tick_nxt;
      coll_r  <= coll_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/ps2_device_command_handshake_unit.sv =====
// An event's result goes to the output register, or to the skid if that is stalled.
// Throughput: one event per cycle while the skid is empty; single-pass sequencer update.
// A two-entry output buffer (output register plus skid) keeps in_tready off out_tready.
// Reset (rst_n low, synchronous) returns to idle, empties the buffer and sets
// wait_ticks to 10 and id_capacity to 32.
// ----------------------------------------------------------------------------
// ps2_device_command_handshake_unit
// Host-side PS/2 command sequencer with stream event input and result output.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2_device_command_handshake_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  wire logic [2:0]  in_tuser,   // [2:0] opcode
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [7:0] payload, [10:8] status, [16:11] id_count, rest 0
  output logic [1:0]       out_tuser,  // [1:0] kind
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [5:0]  cfg_data
);

  logic [ps2dch_pkg::TICK_W-1:0] wait_ticks_r;
  logic [ps2dch_pkg::CFG_W-1:0]  id_cap_r;

  logic                 in_fire;
  logic                 res_valid;
  ps2dch_pkg::res_t     res;

  logic                 out_valid_r, out_valid_nxt;
  ps2dch_pkg::res_t     out_data_r, out_data_nxt;
  logic                 skid_valid_r, skid_valid_nxt;
  ps2dch_pkg::res_t     skid_data_r, skid_data_nxt;

  assign cfg_ready = 1'b1;
  assign in_tready = !skid_valid_r;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wait_ticks_r <= ps2dch_pkg::WAIT_TICKS_RST;
      id_cap_r     <= ps2dch_pkg::ID_CAPACITY_RST;
    end else if (cfg_valid) begin
      if (cfg_index == ps2dch_pkg::REG_WAIT_TICKS) begin
        wait_ticks_r <= cfg_data[ps2dch_pkg::TICK_W-1:0];
      end else begin
        id_cap_r <= cfg_data;
      end
    end
  end

  ps2dch_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .ev_valid    (in_fire),
    .ev_op       (in_tuser),
    .ev_byte     (in_tdata),
    .wait_ticks  (wait_ticks_r),
    .id_capacity (id_cap_r),
    .res_valid   (res_valid),
    .res         (res)
  );

  // skid only fills when the output register is stalled
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = res_valid;
        out_data_nxt  = res;
      end
    end else if (res_valid) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_data_r.kind;
  assign out_tdata  = {7'd0, out_data_r.id_count, out_data_r.status, out_data_r.payload};

endmodule

`default_nettype wire

// ===== design/ps2dch_chk.sv =====
// ----------------------------------------------------------------------------
// ps2dch_chk
// Port-level checks for the PS/2 command handshake unit, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2dch_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [23:0] out_tdata,
  input wire logic [1:0]  out_tuser
);

  // stalled beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output beat changed while stalled");

  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("buffer not empty after reset");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser == ps2dch_pkg::KIND_TX || out_tuser == ps2dch_pkg::KIND_ID ||
                   out_tuser == ps2dch_pkg::KIND_FINISH)
    else $error("illegal result kind");

  a_nonfinish_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ps2dch_pkg::KIND_FINISH |-> out_tdata[23:8] == 16'd0)
    else $error("status or count set on a non-finish beat");

  a_finish_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ps2dch_pkg::KIND_FINISH |->
      out_tdata[7:0] == 8'd0 && out_tdata[10:8] <= 3'd4 &&
      out_tdata[16:11] <= 6'(ps2dch_pkg::MAX_ID_BYTES))
    else $error("bad finish beat fields");

endmodule

bind ps2_device_command_handshake_unit ps2dch_chk u_ps2dch_chk (.*);

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the PS/2 host command sequencer.
// Events go in as stream beats. A cycle-free model of the sequencer predicts
// the result beats the script does not give, and a monitor compares each one
// field by field. A short scripted run covers the protocol corner cases.
// Random device conversations then follow under several timeout and ID
// capacity settings, with random gaps and back-pressure on both streams.
// ----------------------------------------------------------------------------

module tb;

  localparam logic [2:0]          OP_UNDEF_A  = 3'd6;
  localparam logic [2:0]          OP_UNDEF_B  = 3'd7;
  localparam logic [7:0]          B_BAT_FAIL  = 8'hFC;
  localparam int                  PHASES      = 8;
  localparam int                  PHASE_BEATS = 182;
  localparam ps2dch_pkg::res_t    NO_RES      = '0;

  typedef enum logic [3:0] {
    SQ_IDLE, SQ_DIS_ACK, SQ_EN_ACK, SQ_RST_R1, SQ_RST_R2, SQ_RST_DRAIN,
    SQ_ID_ACK, SQ_ID_COLLECT, SQ_ID_EXTRA
  } seq_phase_t;

  typedef struct {
    logic [2:0]       op;
    logic [7:0]       rx;
    int               reps;
    bit               typed;   // want applies to the last repetition
    ps2dch_pkg::res_t want;
  } script_row_t;

  // res_t fields in order: id_count, status, payload, kind
  script_row_t script [32] = '{
    '{ps2dch_pkg::OP_TICK,    8'h00,                 1, 1'b0, NO_RES},
    '{ps2dch_pkg::OP_RXBYTE,  ps2dch_pkg::B_ACK,     1, 1'b0, NO_RES},
    '{OP_UNDEF_A,             8'hFF,                 1, 1'b0, NO_RES},
    '{ps2dch_pkg::OP_RESET,   8'h00,                 1, 1'b1,
      '{6'd0, ps2dch_pkg::ST_OK, ps2dch_pkg::B_DISABLE, ps2dch_pkg::KIND_TX}},
    '{ps2dch_pkg::OP_IDENT,   8'h00,                 1, 1'b0, NO_RES},
    '{OP_UNDEF_B,             8'h00,                 1, 1'b0, NO_RES},
    '{ps2dch_pkg::OP_RXBYTE,  ps2dch_pkg::B_RESEND,  1, 1'b1,
      '{6'd0, ps2dch_pkg::ST_OK, ps2dch_pkg::B_DISABLE, ps2dch_pkg::KIND_TX}},
    '{ps2dch_pkg::OP_RXBYTE,  ps2dch_pkg::B_ACK,     1, 1'b1,
      '{6'd0, ps2dch_pkg::ST_OK, ps2dch_pkg::B_RESET, ps2dch_pkg::KIND_TX}},
    '{ps2dch_pkg::OP_RXBYTE,  B_BAT_FAIL,            1, 1'b1,
      '{6'd0, ps2dch_pkg::ST_INVALID, 8'h00, ps2dch_pkg::KIND_FINISH}},
    '{ps2dch_pkg::OP_RESET,   8'h00,                 1, 1'b0, NO_RES},
    '{ps2dch_pkg::OP_RXBYTE,  ps2dch_pkg::B_ACK,     1, 1'b0, NO_RES},
    '{ps2dch_pkg::OP_TICK,    8'h00,                 2, 1'b1,
      '{6'd0, ps2dch_pkg::ST_NODEV, 8'h00, ps2dch_pkg::KIND_FINISH}},
    '{ps2dch_pkg::OP_RESET,   8'h00,                 1, 1'b0, NO_RES},
    '{ps2dch_pkg::OP_RXBYTE,  ps2dch_pkg::B_ACK,     1, 1'b0, NO_RES},
    '{ps2dch_pkg::OP_RXBYTE,  ps2dch_pkg::B_BAT_OK,  1, 1'b0, NO_RES},
    '{ps2dch_pkg::OP_RXBYTE,  ps2dch_pkg::B_ACK,     1, 1'b0, NO_RES},
    '{ps2dch_pkg::OP_RXBYTE,  8'h5A,                 1, 1'b0, NO_RES},
    '{ps2dch_pkg::OP_TICK,    8'h00,                 2, 1'b1,
      '{6'd0, ps2dch_pkg::ST_OK, 8'h00, ps2dch_pkg::KIND_FINISH}},
    '{ps2dch_pkg::OP_IDENT,   8'h00,                 1, 1'b0, NO_RES},
    '{ps2dch_pkg::OP_RXBYTE,  ps2dch_pkg::B_ACK,     1, 1'b1,
      '{6'd0, ps2dch_pkg::ST_OK, ps2dch_pkg::B_IDENT, ps2dch_pkg::KIND_TX}},
    '{ps2dch_pkg::OP_RXBYTE,  ps2dch_pkg::B_RESEND,  1, 1'b1,
      '{6'd0, ps2dch_pkg::ST_OK, ps2dch_pkg::B_IDENT, ps2dch_pkg::KIND_TX}},
    '{ps2dch_pkg::OP_RXBYTE,  ps2dch_pkg::B_ACK,     1, 1'b0, NO_RES},
    '{ps2dch_pkg::OP_RXBYTE,  8'h00,                 1, 1'b1,
      '{6'd0, ps2dch_pkg::ST_OK, 8'h00, ps2dch_pkg::KIND_ID}},
    '{ps2dch_pkg::OP_RXBYTE,  8'hFF,                 1, 1'b1,
      '{6'd0, ps2dch_pkg::ST_OK, 8'hFF, ps2dch_pkg::KIND_ID}},
    '{ps2dch_pkg::OP_TICK,    8'h00,                 2, 1'b1,
      '{6'd2, ps2dch_pkg::ST_OK, 8'h00, ps2dch_pkg::KIND_FINISH}},
    '{ps2dch_pkg::OP_ENABLE,  8'h00,                 1, 1'b1,
      '{6'd0, ps2dch_pkg::ST_OK, ps2dch_pkg::B_ENABLE, ps2dch_pkg::KIND_TX}},
    '{ps2dch_pkg::OP_RXBYTE,  ps2dch_pkg::B_RESEND,  1, 1'b0, NO_RES},
    '{ps2dch_pkg::OP_RXBYTE,  8'h55,                 1, 1'b1,
      '{6'd0, ps2dch_pkg::ST_INVALID, 8'h00, ps2dch_pkg::KIND_FINISH}},
    '{ps2dch_pkg::OP_DISABLE, 8'h00,                 1, 1'b0, NO_RES},
    '{ps2dch_pkg::OP_RXBYTE,  ps2dch_pkg::B_ACK,     1, 1'b1,
      '{6'd0, ps2dch_pkg::ST_OK, 8'h00, ps2dch_pkg::KIND_FINISH}},
    '{ps2dch_pkg::OP_RESET,   8'h00,                 1, 1'b0, NO_RES},
    '{ps2dch_pkg::OP_RXBYTE,  ps2dch_pkg::B_ACK,     1, 1'b0, NO_RES}
  };

  // register settings per random phase; upper data bits of wait_ticks are dropped
  logic [5:0] wait_set [PHASES] = '{6'd10, 6'd1, 6'h2F, 6'h30, 6'd3, 6'd6, 6'd4, 6'd15};
  logic [5:0] cap_set  [PHASES] = '{6'd32, 6'd1, 6'h3F, 6'd0, 6'd4, 6'd32, 6'd2, 6'd1};

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] rx_byte
  logic [2:0]  in_tuser;   // [2:0] opcode
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // [7:0] payload, [10:8] status, [16:11] id_count
  logic [1:0]  out_tuser;  // [1:0] kind
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [5:0]  cfg_data;

  ps2_device_command_handshake_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // sequencer shadow state
  seq_phase_t        seq_phase;
  ps2dch_pkg::cmd_t  seq_cmd;
  int                idle_ticks;
  logic [5:0]        id_got;
  logic [3:0]        cfg_wait;
  logic [5:0]        cfg_cap;

  ps2dch_pkg::res_t  pending_results [$];
  ps2dch_pkg::res_t  head_result;
  int                errors;
  int                send_idle_pct;
  int                recv_stall_pct;
  bit                chase_timeout;

  function automatic ps2dch_pkg::res_t make_res(ps2dch_pkg::kind_t k, logic [7:0] p,
                                                ps2dch_pkg::status_t s, logic [5:0] n);
    ps2dch_pkg::res_t r;
    r.kind = k;
    r.payload = p;
    r.status = s;
    r.id_count = n;
    return r;
  endfunction

  function automatic ps2dch_pkg::res_t seq_send(seq_phase_t nxt, logic [7:0] b);
    seq_phase = nxt;
    idle_ticks = 0;
    return make_res(ps2dch_pkg::KIND_TX, b, ps2dch_pkg::ST_OK, 6'd0);
  endfunction

  function automatic ps2dch_pkg::res_t seq_finish(ps2dch_pkg::status_t s);
    seq_phase = SQ_IDLE;
    idle_ticks = 0;
    return make_res(ps2dch_pkg::KIND_FINISH, 8'h00, s,
                    (seq_cmd == ps2dch_pkg::CMD_IDENT) ? id_got : 6'd0);
  endfunction

  // Advances the shadow sequencer by one event; returns 1 when a result beat follows.
  function automatic bit host_seq_step(input logic [2:0] op, input logic [7:0] rx,
                                       output ps2dch_pkg::res_t r);
    int cap;
    bit hit;
    hit = 1'b0;
    r = NO_RES;
    cap = (cfg_cap == 6'd0) ? 1 :
          ((int'(cfg_cap) > ps2dch_pkg::MAX_ID_BYTES) ? ps2dch_pkg::MAX_ID_BYTES
                                                      : int'(cfg_cap));
    if (op <= ps2dch_pkg::OP_DISABLE) begin
      if (seq_phase == SQ_IDLE) begin
        seq_cmd = ps2dch_pkg::cmd_t'(op[1:0]);
        id_got = '0;
        hit = 1'b1;
        r = (op == ps2dch_pkg::OP_ENABLE) ? seq_send(SQ_EN_ACK, ps2dch_pkg::B_ENABLE)
                                          : seq_send(SQ_DIS_ACK, ps2dch_pkg::B_DISABLE);
      end
    end else if (seq_phase != SQ_IDLE && op == ps2dch_pkg::OP_RXBYTE) begin
      idle_ticks = 0;
      case (seq_phase)
        SQ_DIS_ACK: begin
          hit = 1'b1;
          if (rx == ps2dch_pkg::B_RESEND) r = seq_send(SQ_DIS_ACK, ps2dch_pkg::B_DISABLE);
          else if (rx != ps2dch_pkg::B_ACK) r = seq_finish(ps2dch_pkg::ST_INVALID);
          else if (seq_cmd == ps2dch_pkg::CMD_RESET) r = seq_send(SQ_RST_R1, ps2dch_pkg::B_RESET);
          else if (seq_cmd == ps2dch_pkg::CMD_IDENT) r = seq_send(SQ_ID_ACK, ps2dch_pkg::B_IDENT);
          else r = seq_finish(ps2dch_pkg::ST_OK);
        end
        SQ_EN_ACK: begin
          hit = 1'b1;
          if (rx == ps2dch_pkg::B_RESEND) r = seq_send(SQ_EN_ACK, ps2dch_pkg::B_ENABLE);
          else r = seq_finish((rx == ps2dch_pkg::B_ACK) ? ps2dch_pkg::ST_OK
                                                        : ps2dch_pkg::ST_INVALID);
        end
        SQ_RST_R1, SQ_RST_R2: begin
          if (rx != ps2dch_pkg::B_ACK && rx != ps2dch_pkg::B_BAT_OK) begin
            hit = 1'b1;
            r = seq_finish(ps2dch_pkg::ST_INVALID);
          end else begin
            seq_phase = (seq_phase == SQ_RST_R1) ? SQ_RST_R2 : SQ_RST_DRAIN;
          end
        end
        SQ_ID_ACK: begin
          if (rx == ps2dch_pkg::B_RESEND) begin
            hit = 1'b1;
            r = seq_send(SQ_ID_ACK, ps2dch_pkg::B_IDENT);
          end else if (rx != ps2dch_pkg::B_ACK) begin
            hit = 1'b1;
            r = seq_finish(ps2dch_pkg::ST_INVALID);
          end else begin
            seq_phase = SQ_ID_COLLECT;
            id_got = '0;
          end
        end
        SQ_ID_COLLECT: begin
          id_got = id_got + 6'd1;
          if (int'(id_got) >= cap) seq_phase = SQ_ID_EXTRA;
          hit = 1'b1;
          r = make_res(ps2dch_pkg::KIND_ID, rx, ps2dch_pkg::ST_OK, 6'd0);
        end
        SQ_ID_EXTRA: begin
          hit = 1'b1;
          r = seq_finish(ps2dch_pkg::ST_TOOLONG);
        end
        default: ;
      endcase
    end else if (seq_phase != SQ_IDLE && op == ps2dch_pkg::OP_TICK) begin
      idle_ticks++;
      if (idle_ticks >= int'(cfg_wait)) begin
        hit = 1'b1;
        case (seq_phase)
          SQ_RST_R1: r = seq_finish(ps2dch_pkg::ST_NODEV);
          SQ_RST_DRAIN, SQ_ID_COLLECT, SQ_ID_EXTRA: r = seq_finish(ps2dch_pkg::ST_OK);
          default: r = seq_finish(ps2dch_pkg::ST_TIMEOUT);
        endcase
      end
    end
    return hit;
  endfunction

  // Device-like event picker: mostly well-formed replies, some noise and timeouts.
  function automatic void pick_event(output logic [2:0] op, output logic [7:0] rx);
    int unsigned r;
    r = $urandom_range(0, 99);
    rx = 8'($urandom);
    op = ps2dch_pkg::OP_TICK;
    if (seq_phase == SQ_IDLE) begin
      chase_timeout = 1'b0;
      if (r < 28) op = ps2dch_pkg::OP_RESET;
      else if (r < 58) op = ps2dch_pkg::OP_IDENT;
      else if (r < 74) op = ps2dch_pkg::OP_ENABLE;
      else if (r < 88) op = ps2dch_pkg::OP_DISABLE;
      else if (r < 93) op = ps2dch_pkg::OP_RXBYTE;
      else if (r < 96) op = ps2dch_pkg::OP_TICK;
      else op = r[0] ? OP_UNDEF_A : OP_UNDEF_B;
      return;
    end
    if (chase_timeout) begin
      if (r < 3) op = 3'($urandom_range(0, 3));
      else if (r < 6) op = r[0] ? OP_UNDEF_A : OP_UNDEF_B;
      return;
    end
    case (seq_phase)
      SQ_DIS_ACK, SQ_EN_ACK, SQ_ID_ACK: begin
        if (r < 70) begin op = ps2dch_pkg::OP_RXBYTE; rx = ps2dch_pkg::B_ACK; end
        else if (r < 80) begin op = ps2dch_pkg::OP_RXBYTE; rx = ps2dch_pkg::B_RESEND; end
        else if (r < 86) op = ps2dch_pkg::OP_RXBYTE;
        else if (r < 91) chase_timeout = 1'b1;
        else if (r >= 95) op = 3'($urandom_range(0, 3));
      end
      SQ_RST_R1, SQ_RST_R2: begin
        op = ps2dch_pkg::OP_RXBYTE;
        if (r < 40) rx = ps2dch_pkg::B_ACK;
        else if (r < 78) rx = ps2dch_pkg::B_BAT_OK;
        else if (r < 83) rx = B_BAT_FAIL;
        else if (r >= 88) begin
          op = ps2dch_pkg::OP_TICK;
          chase_timeout = (r < 93);
        end
      end
      SQ_RST_DRAIN: begin
        if (r < 35) op = ps2dch_pkg::OP_RXBYTE;
        else if (r < 70) chase_timeout = 1'b1;
      end
      default: begin
        if (r < 78) op = ps2dch_pkg::OP_RXBYTE;
        else if (r < 90) chase_timeout = 1'b1;
      end
    endcase
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("end of test: mismatches");
    $finish;
  end

  always @(negedge clk) begin
    out_tready = ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: kind %0d payload %02h", out_tuser,
               out_tdata[7:0]);
        errors++;
      end else begin
        head_result = pending_results.pop_front();
        if (out_tuser !== head_result.kind) begin
          $error("kind: expected %0d, actual %0d", head_result.kind, out_tuser);
          errors++;
        end
        if (out_tdata[7:0] !== head_result.payload) begin
          $error("payload: expected %02h, actual %02h", head_result.payload, out_tdata[7:0]);
          errors++;
        end
        if (out_tdata[10:8] !== head_result.status) begin
          $error("status: expected %0d, actual %0d", head_result.status, out_tdata[10:8]);
          errors++;
        end
        if (out_tdata[16:11] !== head_result.id_count) begin
          $error("id_count: expected %0d, actual %0d", head_result.id_count,
                 out_tdata[16:11]);
          errors++;
        end
      end
    end
  end

  // Entered and left at a falling edge; in_tvalid stays high for a following beat.
  task automatic send_event(input logic [2:0] op, input logic [7:0] rx, input bit typed,
                            input ps2dch_pkg::res_t want, output bit counted);
    ps2dch_pkg::res_t pred;
    bit               has;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser = op;
    in_tdata = rx;
    do @(posedge clk); while (!in_tready);
    counted = (op <= ps2dch_pkg::OP_DISABLE) ?
              (seq_phase == SQ_IDLE) :
              ((op == ps2dch_pkg::OP_RXBYTE || op == ps2dch_pkg::OP_TICK) &&
               seq_phase != SQ_IDLE);
    has = host_seq_step(op, rx, pred);
    if (typed) pending_results.push_back(want);
    else if (has) pending_results.push_back(pred);
    @(negedge clk);
  endtask

  task automatic write_reg(input ps2dch_pkg::reg_idx_t idx, input logic [5:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == ps2dch_pkg::REG_WAIT_TICKS) cfg_wait = val[3:0];
    else cfg_cap = val;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // run the sequencer back to idle, then let every result beat drain
  task automatic settle_idle();
    bit unused;
    while (seq_phase != SQ_IDLE) send_event(ps2dch_pkg::OP_TICK, 8'h00, 1'b0, NO_RES, unused);
    in_tvalid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    logic [2:0] op;
    logic [7:0] rx;
    bit         counted;
    int         n;

    errors = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    chase_timeout = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = 1'b0;
    cfg_data = '0;
    seq_phase = SQ_IDLE;
    seq_cmd = ps2dch_pkg::CMD_RESET;
    idle_ticks = 0;
    id_got = '0;
    cfg_wait = ps2dch_pkg::WAIT_TICKS_RST;
    cfg_cap = ps2dch_pkg::ID_CAPACITY_RST;

    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // short timeouts keep the scripted run brief
    write_reg(ps2dch_pkg::REG_WAIT_TICKS, 6'd2);
    foreach (script[i]) begin
      for (int k = 1; k <= script[i].reps; k++) begin
        send_event(script[i].op, script[i].rx, script[i].typed && k == script[i].reps,
                   script[i].want, counted);
      end
    end
    settle_idle();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
        default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
      write_reg(ps2dch_pkg::REG_WAIT_TICKS, wait_set[ph]);
      write_reg(ps2dch_pkg::REG_ID_CAPACITY, cap_set[ph]);
      n = 0;
      while (n < PHASE_BEATS) begin
        pick_event(op, rx);
        send_event(op, rx, 1'b0, NO_RES, counted);
        if (counted) n++;
      end
      settle_idle();
    end

    repeat (10) @(negedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
